// ----- hw/rtl/bf5_pkg.sv -----
// bf5_pkg: shared types and constants of the 5x5 bilateral filter unit
// used by bf5_ctrl, bf5_datapath and bilateral_filter_5x5_u8_unit; no dependencies
`default_nettype none

package bf5_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 8;
  localparam int WIN_W      = 16;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int POS_W      = 24;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;
  localparam int NUM_TAPS   = 25;
  localparam int MAX_HEIGHT = 4096;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_SPATIAL = 2'd1,
    ACT_RANGE   = 2'd2,
    ACT_FLUSH   = 2'd3
  } act_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_CHECK,
    ST_CENTER,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       rd_center;
    logic       rd_tap;
    logic       acc_clear;
    logic       div_load;
    logic       div_step;
    logic       load_result;
    logic [4:0] k;
    logic [2:0] dy;
    logic [2:0] dx;
    logic [2:0] div_i;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t action;
    logic emit_ok;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bf5_ctrl.sv -----
// bf5_ctrl: sequencing state machine of the bilateral filter
// depends on bf5_pkg; drives bf5_datapath through cmd_t and reads status_t
`default_nettype none

module bf5_ctrl
  import bf5_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_we,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t     state, state_next;
  logic [4:0] k, k_next;
  logic [2:0] dy, dy_next;
  logic [2:0] dx, dx_next;
  logic [2:0] div_i, div_i_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      dy    <= '0;
      dx    <= '0;
      div_i <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      dy    <= dy_next;
      dx    <= dx_next;
      div_i <= div_i_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    dy_next    = dy;
    dx_next    = dx;
    div_i_next = div_i;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.k      = k;
    cmd.dy     = dy;
    cmd.dx     = dx;
    cmd.div_i  = div_i;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (cfg_we) begin
          state_next = ST_SETTLE;
        end else if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (st.action == ACT_PIXEL || st.action == ACT_FLUSH) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SETTLE: begin
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        state_next = st.emit_ok ? ST_CENTER : ST_IDLE;
      end
      ST_CENTER: begin
        cmd.rd_center = 1'b1;
        cmd.acc_clear = 1'b1;
        k_next        = '0;
        dy_next       = '0;
        dx_next       = '0;
        state_next    = ST_TAPS;
      end
      ST_TAPS: begin
        cmd.rd_tap = 1'b1;
        if (k == 5'(NUM_TAPS - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k + 5'd1;
          if (dx == 3'd4) begin
            dx_next = '0;
            dy_next = dy + 3'd1;
          end else begin
            dx_next = dx + 3'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        div_i_next   = 3'd7;
        state_next   = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (div_i == 3'd0) begin
          state_next = ST_RESULT;
        end else begin
          div_i_next = div_i - 3'd1;
        end
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> st.out_free) else $error("result loaded over pending output");

  // division starts only after the tap pipeline has drained
  a_div_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> !st.pipe_busy) else $error("division started with taps in flight");

  // tap walk ends on the last tap of the window
  a_taps_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAPS && state_next == ST_DRAIN) |-> (dy == 3'd4 && dx == 3'd4))
    else $error("tap walk ended early");

endmodule

`default_nettype wire

// ----- hw/rtl/bf5_datapath.sv -----
// bf5_datapath: line store, weight tables, tap pipeline, divider and output register
// depends on bf5_pkg; controlled by bf5_ctrl through cmd_t
`default_nettype none

module bf5_datapath
  import bf5_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast,
  input  wire cmd_t                  cmd,
  output status_t                    st
);

  localparam int LINE_DEPTH = 5 * MAX_WIDTH;
  localparam int LA = $clog2(LINE_DEPTH);
  localparam int WB = WEIGHT_BITS;
  localparam int PW = 2 * WB;
  localparam int WS = PW + 5;
  localparam int VS = PW + 13;
  localparam int AW = PW + 14;

  function automatic logic [LA-1:0] wrap_add(input logic [LA-1:0] a, input logic [LA:0] b);
    logic [LA:0] s;
    s = {1'b0, a} + b;
    if (s >= (LA+1)'(LINE_DEPTH)) s = s - (LA+1)'(LINE_DEPTH);
    return s[LA-1:0];
  endfunction

  // request fields
  act_t             action;
  logic [PIX_W-1:0] in_pixel;
  logic [IDX_W-1:0] in_index;
  logic [WB-1:0]    in_weight;
  assign action    = act_t'(s_tuser);
  assign in_pixel  = s_tdata[7:0];
  assign in_index  = s_tdata[15:8];
  assign in_weight = WB'(s_tdata[31:16]);

  // configuration and frame geometry
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [WIDTH_W-1:0]  weff;
  logic [HEIGHT_W-1:0] heff;
  logic [POS_W-1:0]    total;

  always_comb begin
    if (frame_width == '0) weff = WIDTH_W'(1);
    else if (32'(frame_width) > MAX_WIDTH) weff = WIDTH_W'(MAX_WIDTH);
    else weff = frame_width;
    if (frame_height == '0) heff = HEIGHT_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) heff = HEIGHT_W'(MAX_HEIGHT);
    else heff = frame_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_W'(1920);
      frame_height <= HEIGHT_W'(1080);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size product, registered, so it settles the cycle after a register write
  always_ff @(posedge clk) begin
    total <= POS_W'(weff) * POS_W'(heff);
  end

  // register write delayed by one register, so row bases reload from the new width
  logic cfg_we_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_we_q <= 1'b0;
    end else begin
      cfg_we_q <= cfg_we;
    end
  end

  // positions and output coordinates
  logic [POS_W-1:0]   in_pos, out_pos;
  logic [LA-1:0]      wr_addr;
  logic [WIDTH_W-1:0] x, y;
  logic [LA-1:0]      rb [5];
  logic               wr_en, is_last, restart;

  assign wr_en   = cmd.accept && action == ACT_PIXEL && in_pos < total;
  assign is_last = out_pos == total - POS_W'(1);
  assign restart = cfg_we || cfg_we_q || (cmd.load_result && is_last);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_pos  <= '0;
      out_pos <= '0;
      wr_addr <= '0;
      x       <= '0;
      y       <= '0;
      rb[0]   <= '0;
      rb[1]   <= '0;
      rb[2]   <= '0;
      rb[3]   <= LA'(weff);
      rb[4]   <= LA'({weff, 1'b0});
    end else begin
      if (wr_en) begin
        in_pos  <= in_pos + POS_W'(1);
        wr_addr <= (wr_addr == LA'(LINE_DEPTH - 1)) ? '0 : wr_addr + LA'(1);
      end
      if (cmd.load_result) begin
        out_pos <= out_pos + POS_W'(1);
        if (x == weff - WIDTH_W'(1)) begin
          x     <= '0;
          y     <= y + WIDTH_W'(1);
          rb[0] <= rb[1];
          rb[1] <= rb[2];
          rb[2] <= rb[3];
          rb[3] <= rb[4];
          rb[4] <= wrap_add(rb[4], (LA+1)'(weff));
        end else begin
          x <= x + WIDTH_W'(1);
        end
      end
    end
  end

  // tap address with edge clamping
  logic [HEIGHT_W-1:0] yyp;
  logic [HEIGHT_W-1:0] xp;
  logic [2:0]          ridx;
  logic [WIDTH_W-1:0]  xx;
  logic [LA-1:0]       tap_addr, cen_addr, rd_addr;

  always_comb begin
    yyp = {1'b0, y} + HEIGHT_W'(cmd.dy);
    if (yyp < HEIGHT_W'(2)) yyp = HEIGHT_W'(2);
    else if (yyp > heff + HEIGHT_W'(1)) yyp = heff + HEIGHT_W'(1);
    ridx = 3'(yyp - {1'b0, y});
    xp = {1'b0, x} + HEIGHT_W'(cmd.dx);
    if (xp < HEIGHT_W'(2)) xp = HEIGHT_W'(2);
    else if (xp > {1'b0, weff} + HEIGHT_W'(1)) xp = {1'b0, weff} + HEIGHT_W'(1);
    xx = WIDTH_W'(xp - HEIGHT_W'(2));
    tap_addr = wrap_add(rb[ridx], (LA+1)'(xx));
    cen_addr = wrap_add(rb[2], (LA+1)'(x));
    rd_addr  = cmd.rd_center ? cen_addr : tap_addr;
  end

  // line store
  logic [PIX_W-1:0] line_mem [LINE_DEPTH];
  logic [PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr] <= in_pixel;
    if (cmd.rd_center || cmd.rd_tap) rd_data <= line_mem[rd_addr];
  end

  // weight tables
  logic [WB-1:0] spatial_w [NUM_TAPS];
  logic [WB-1:0] range_mem [256];

  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_SPATIAL && in_index < IDX_W'(NUM_TAPS)) begin
      spatial_w[in_index[4:0]] <= in_weight;
    end
  end

  // tap pipeline valids
  logic s1_cen, s1_tap, s2, s3, s4;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cen <= 1'b0;
      s1_tap <= 1'b0;
      s2     <= 1'b0;
      s3     <= 1'b0;
      s4     <= 1'b0;
    end else begin
      s1_cen <= cmd.rd_center;
      s1_tap <= cmd.rd_tap;
      s2     <= s1_tap;
      s3     <= s2;
      s4     <= s3;
    end
  end

  // tap pipeline payload
  logic [PIX_W-1:0] center, v2, v3;
  logic [PIX_W-1:0] diff;
  logic [WB-1:0]    sw1, sw2, rw2;
  logic [PW-1:0]    prod3;
  logic [PW+7:0]    pv4;
  logic [WS-1:0]    wsum;
  logic [VS-1:0]    vsum;

  assign diff = (rd_data > center) ? rd_data - center : center - rd_data;

  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_RANGE) range_mem[in_index] <= in_weight;
    if (s1_tap) rw2 <= range_mem[diff];
  end

  always_ff @(posedge clk) begin
    if (s1_cen) center <= rd_data;
    sw1   <= spatial_w[cmd.k];
    sw2   <= sw1;
    v2    <= rd_data;
    prod3 <= sw2 * rw2;
    v3    <= v2;
    pv4   <= prod3 * v3;
    if (cmd.acc_clear) begin
      wsum <= '0;
      vsum <= '0;
    end else begin
      if (s3) wsum <= wsum + WS'(prod3);
      if (s4) vsum <= vsum + VS'(pv4);
    end
  end

  // restoring division, one quotient bit per step
  logic [AW-1:0]    num, den, den_sh;
  logic [AW-1:0]    rem;
  logic [PIX_W-1:0] quo;
  logic             over;
  logic [PIX_W-1:0] res_pix;

  assign num    = {vsum, 1'b0} + AW'(wsum);
  assign den    = AW'({wsum, 1'b0});
  assign den_sh = den << cmd.div_i;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= num;
      quo  <= '0;
      over <= num >= (den << 8);
    end else if (cmd.div_step && rem >= den_sh) begin
      rem            <= rem - den_sh;
      quo[cmd.div_i] <= 1'b1;
    end
  end

  always_comb begin
    if (wsum == '0) res_pix = center;
    else if (over) res_pix = PIX_W'(255);
    else res_pix = quo;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      m_tdata <= res_pix;
      m_tlast <= is_last;
    end
  end

  // status
  always_comb begin
    st.action    = action;
    st.pipe_busy = s1_tap || s2 || s3 || s4;
    st.out_free  = !m_tvalid || m_tready;
    st.emit_ok   = (out_pos < total) &&
                   ((in_pos >= total) ||
                    ((POS_W+1)'(in_pos) >= (POS_W+1)'(out_pos) +
                     (POS_W+1)'({weff, 1'b0}) + (POS_W+1)'(3)));
  end

  // output never runs ahead of input
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_pos <= in_pos) else $error("output position passed input position");

  // column stays inside the row
  a_col: assert property (@(posedge clk) disable iff (rst)
    x < weff) else $error("column out of range");

  // center is captured before the first tap reaches the range lookup
  a_center: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_center |=> s1_cen && !s1_tap) else $error("center read overlapped a tap");

endmodule

`default_nettype wire

// ----- hw/rtl/bilateral_filter_5x5_u8_unit.sv -----
// bilateral_filter_5x5_u8_unit: top level of the streaming 5x5 bilateral filter
// depends on bf5_pkg, bf5_ctrl and bf5_datapath
//
// channel   direction  handshake          payload
// s_axis    in         s_tvalid/s_tready  tdata: pixel, table_index, weight; tuser: action
// m_axis    out        m_tvalid/m_tready  tdata: filtered_pixel; tlast: frame_last
// cfg       in         cfg_we             cfg_index, cfg_wdata
//
// a weight write leaves the unit idle, a request that yields no output returns to idle from check
// an output pixel passes from accept through check, center read, 25 taps through one
// line store read port, pipeline drain, divider load, 8 divider steps and result
// a register write holds s_tready low through the settle state while the frame size settles
// reset (rst, synchronous) clears positions and control; weights and line store stay undefined
// a stalled output holds in its register while the next request is taken
`default_nettype none

module bilateral_filter_5x5_u8_unit
  import bf5_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pixel[7:0], table_index[15:8], weight[31:16]
  input  wire logic [1:0]            s_tuser,   // action[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // filtered_pixel[7:0]
  output logic                       m_tlast
);

  cmd_t    cmd;
  status_t st;

  bf5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bf5_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
